/* design/adts_pkg.sv */
// shared types, constants and the sampling rate table for the adts header builder
// no dependencies
`timescale 1ns / 1ps

package adts_pkg;

   localparam int PROFILE_W  = 8;
   localparam int RATE_W     = 18;
   localparam int CHANNEL_W  = 4;
   localparam int PAYLOAD_W  = 13;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int SFI_W      = 4;
   localparam int CHAN_CFG_W = 3;
   localparam int RATE_COUNT = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // reset values
   localparam logic [PROFILE_W-1:0] PROFILE_RESET = 8'd1;
   localparam logic [RATE_W-1:0]    RATE_RESET    = 18'd44100;
   localparam logic [CHANNEL_W-1:0] CHANNEL_RESET = 4'd2;

   // profile codes
   localparam logic [PROFILE_W-1:0] PROFILE_MAIN = 8'd0;
   localparam logic [PROFILE_W-1:0] PROFILE_SSR  = 8'd2;
   localparam logic [PROFILE_W-1:0] PROFILE_LTP  = 8'd3;
   localparam logic [PROFILE_W-1:0] PROFILE_HE   = 8'd4;
   localparam logic [PROFILE_W-1:0] PROFILE_HEV2 = 8'd28;

   // fixed header bytes
   localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hff;
   localparam logic [BYTE_W-1:0] ID_BYTE      = 8'hf1;
   localparam logic [BYTE_W-1:0] TAIL_BYTE    = 8'hfc;
   localparam logic [4:0]        FULLNESS_HI  = 5'h1f;
   localparam logic [PAYLOAD_W-1:0] HEADER_LEN = 13'd7;
   localparam logic [SFI_W-1:0]  SFI_DEFAULT  = 4'd4;

   typedef struct packed {
      logic [1:0]            profile;
      logic [SFI_W-1:0]      sfi;
      logic [CHAN_CFG_W-1:0] chan_cfg;
   } hdr_fields_type;

   function automatic logic [RATE_W-1:0] rate_entry(input logic [SFI_W-1:0] idx);
      logic [RATE_W-1:0] r;
      case (idx)
         4'd0:    r = 18'd96000;
         4'd1:    r = 18'd88200;
         4'd2:    r = 18'd64000;
         4'd3:    r = 18'd48000;
         4'd4:    r = 18'd44100;
         4'd5:    r = 18'd32000;
         4'd6:    r = 18'd24000;
         4'd7:    r = 18'd22050;
         4'd8:    r = 18'd16000;
         4'd9:    r = 18'd12000;
         4'd10:   r = 18'd11025;
         4'd11:   r = 18'd8000;
         4'd12:   r = 18'd7350;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* design/adts_field_decode.sv */
// decodes profile, sample rate and channel count into the header's coded fields
// depends on adts_pkg
`timescale 1ns / 1ps

module adts_field_decode (
   input  logic [adts_pkg::PROFILE_W-1:0] profile_code,
   input  logic [adts_pkg::RATE_W-1:0]    rate_hz,
   input  logic [adts_pkg::CHANNEL_W-1:0] channel_count,
   output adts_pkg::hdr_fields_type       fields
);
   import adts_pkg::*;

   logic [RATE_W-1:0]    rate_eff;
   logic [CHANNEL_W-1:0] chan_eff;
   logic                 is_he;
   logic                 is_hev2;
   logic [SFI_W-1:0]     sfi;
   logic                 hit;

   assign is_hev2  = (profile_code == PROFILE_HEV2);
   assign is_he    = (profile_code == PROFILE_HE) || is_hev2;
   assign rate_eff = is_he ? (rate_hz >> 1) : rate_hz;
   assign chan_eff = is_hev2 ? (channel_count >> 1) : channel_count;

   // first match wins, table entries are distinct
   always_comb begin
      sfi = SFI_DEFAULT;
      hit = 1'b0;
      for (int k = 0; k < RATE_COUNT; k++) begin
         if (!hit && rate_eff == rate_entry(SFI_W'(k))) begin
            sfi = SFI_W'(k);
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      if (profile_code == PROFILE_MAIN || profile_code == PROFILE_SSR
          || profile_code == PROFILE_LTP) begin
         fields.profile = profile_code[1:0];
      end else begin
         fields.profile = 2'd1;
      end
      fields.sfi      = sfi;
      fields.chan_cfg = chan_eff[CHAN_CFG_W-1:0];
   end

endmodule

/* design/adts_header_builder.sv */
// top level of the adts header builder: config registers, input and result stages
// depends on adts_pkg and adts_field_decode
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_payload_length
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_header_byte_0 .. rsp_header_byte_6
//  csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// one item per cycle while the result is not stalled; an item taken into the input stage is
// packed into the result register and leaves from there
// reset (synchronous) clears both stage valid flags and loads the register defaults
// rsp_stall holds the result register; the input stage still takes one more item
// req_stall rises only when both stages are full and the result is stalled

module adts_header_builder (
   input  logic        clock,
   input  logic        reset,
   // config writes
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_write_data,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [12:0] req_payload_length,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_header_byte_0,
   output logic [7:0]  rsp_header_byte_1,
   output logic [7:0]  rsp_header_byte_2,
   output logic [7:0]  rsp_header_byte_3,
   output logic [7:0]  rsp_header_byte_4,
   output logic [7:0]  rsp_header_byte_5,
   output logic [7:0]  rsp_header_byte_6
);
   import adts_pkg::*;

   // config registers
   logic [PROFILE_W-1:0] profile_ff;
   logic [RATE_W-1:0]    rate_ff;
   logic [CHANNEL_W-1:0] chan_ff;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [PAYLOAD_W-1:0] s1_len_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    byte2_ff, byte3_ff, byte4_ff, byte5_ff;

   logic                 req_take;
   logic                 out_free;
   logic                 s1_move;
   logic [PAYLOAD_W-1:0] frame_len;
   hdr_fields_type       fields;

   // registers must change only while no item is in flight; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= PROFILE_RESET;
         rate_ff    <= RATE_RESET;
         chan_ff    <= CHANNEL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PROFILE_CODE:  profile_ff <= csr_write_data[PROFILE_W-1:0];
            CSR_SAMPLE_RATE:   rate_ff    <= csr_write_data[RATE_W-1:0];
            CSR_CHANNEL_COUNT: chan_ff    <= csr_write_data[CHANNEL_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   adts_field_decode u_decode (
      .profile_code  (profile_ff),
      .rate_hz       (rate_ff),
      .channel_count (chan_ff),
      .fields        (fields)
   );

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_len_ff <= req_payload_length;
      end
   end

   // frame length wraps at 13 bits
   assign frame_len = s1_len_ff + HEADER_LEN;

   // pack the variable bytes
   always_ff @(posedge clock) begin
      if (s1_move) begin
         byte2_ff <= {fields.profile, fields.sfi, 1'b0, fields.chan_cfg[2]};
         byte3_ff <= {fields.chan_cfg[1:0], 4'b0000, frame_len[12:11]};
         byte4_ff <= frame_len[10:3];
         byte5_ff <= {frame_len[2:0], FULLNESS_HI};
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_header_byte_0 = SYNC_BYTE;
   assign rsp_header_byte_1 = ID_BYTE;
   assign rsp_header_byte_2 = byte2_ff;
   assign rsp_header_byte_3 = byte3_ff;
   assign rsp_header_byte_4 = byte4_ff;
   assign rsp_header_byte_5 = byte5_ff;
   assign rsp_header_byte_6 = TAIL_BYTE;

endmodule

/* design/adts_checker.sv */
// port-level checks for the adts header builder, bound to the top level
// depends on adts_header_builder ports only
`timescale 1ns / 1ps

module adts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_header_byte_0,
   input logic [7:0] rsp_header_byte_1,
   input logic [7:0] rsp_header_byte_3,
   input logic [7:0] rsp_header_byte_4,
   input logic [7:0] rsp_header_byte_5,
   input logic [7:0] rsp_header_byte_6
);

   // an empty result stage means the input side is never held off
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall high with empty result stage");

   // fixed bytes and fields of every header
   a_fixed_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_header_byte_0 == 8'hff) && (rsp_header_byte_1 == 8'hf1)
                    && (rsp_header_byte_6 == 8'hfc) && (rsp_header_byte_5[4:0] == 5'h1f)
                    && (rsp_header_byte_3[5:2] == 4'h0))
      else $error("fixed header field wrong");

   // input is held off only behind a waiting result that is itself stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // a stalled result stays valid and holds bytes 3 to 5
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_header_byte_3)
                                 && $stable(rsp_header_byte_4) && $stable(rsp_header_byte_5))
      else $error("stalled result changed");

endmodule

bind adts_header_builder adts_checker u_adts_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_header_byte_0 (rsp_header_byte_0),
   .rsp_header_byte_1 (rsp_header_byte_1),
   .rsp_header_byte_3 (rsp_header_byte_3),
   .rsp_header_byte_4 (rsp_header_byte_4),
   .rsp_header_byte_5 (rsp_header_byte_5),
   .rsp_header_byte_6 (rsp_header_byte_6)
);

/* test/tb_top.sv */
// self-checking testbench for adts_header_builder: header predictor, drivers and result monitor
// depends on adts_pkg and the adts_header_builder rtl
`timescale 1ns / 1ps

import adts_pkg::*;

// seven header bytes, byte 0 leftmost
typedef logic [0:6][BYTE_W-1:0] adts_header_type;

// keeps a mirror of the config registers, predicts the header of every accepted
// frame and checks the headers coming out in order
class header_scoreboard;
   localparam int MAX_REPORTS = 10;

   logic [PROFILE_W-1:0] profile_code;
   logic [RATE_W-1:0]    rate_hz;
   logic [CHANNEL_W-1:0] channel_count;
   adts_header_type      pending_headers[$];
   int unsigned          failures;
   int unsigned          checked;

   function new();
      profile_code  = PROFILE_RESET;
      rate_hz       = RATE_RESET;
      channel_count = CHANNEL_RESET;
      failures      = 0;
      checked       = 0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PROFILE_CODE:  profile_code  = data[PROFILE_W-1:0];
         CSR_SAMPLE_RATE:   rate_hz       = data[RATE_W-1:0];
         CSR_CHANNEL_COUNT: channel_count = data[CHANNEL_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [SFI_W-1:0] sampling_index(logic [RATE_W-1:0] rate);
      case (rate)
         18'd96000: return 4'd0;
         18'd88200: return 4'd1;
         18'd64000: return 4'd2;
         18'd48000: return 4'd3;
         18'd44100: return 4'd4;
         18'd32000: return 4'd5;
         18'd24000: return 4'd6;
         18'd22050: return 4'd7;
         18'd16000: return 4'd8;
         18'd12000: return 4'd9;
         18'd11025: return 4'd10;
         18'd8000:  return 4'd11;
         18'd7350:  return 4'd12;
         default:   return SFI_DEFAULT;
      endcase
   endfunction

   function adts_header_type build_header(logic [PAYLOAD_W-1:0] payload_length);
      logic [1:0]            object_minus_one;
      logic [RATE_W-1:0]     rate;
      logic [CHANNEL_W-1:0]  chans;
      logic [CHAN_CFG_W-1:0] chan_cfg;
      logic [PAYLOAD_W-1:0]  frame_length;
      adts_header_type       hdr;
      // main, ssr and ltp map to code + 1, anything else is lc
      if (profile_code == PROFILE_MAIN || profile_code == PROFILE_SSR ||
          profile_code == PROFILE_LTP)
         object_minus_one = profile_code[1:0];
      else
         object_minus_one = 2'd1;
      rate = rate_hz;
      if (profile_code == PROFILE_HE || profile_code == PROFILE_HEV2)
         rate = rate_hz >> 1;
      chans = channel_count;
      if (profile_code == PROFILE_HEV2)
         chans = channel_count >> 1;
      chan_cfg     = chans[CHAN_CFG_W-1:0];
      frame_length = payload_length + HEADER_LEN;
      hdr[0] = SYNC_BYTE;
      hdr[1] = ID_BYTE;
      hdr[2] = {object_minus_one, sampling_index(rate), 1'b0, chan_cfg[2]};
      hdr[3] = {chan_cfg[1:0], 4'b0000, frame_length[12:11]};
      hdr[4] = frame_length[10:3];
      hdr[5] = {frame_length[2:0], FULLNESS_HI};
      hdr[6] = TAIL_BYTE;
      return hdr;
   endfunction

   function void note_frame(logic [PAYLOAD_W-1:0] payload_length);
      pending_headers.push_back(build_header(payload_length));
   endfunction

   function void check_header(adts_header_type got);
      adts_header_type want;
      if (pending_headers.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("ERROR: header %h arrived with nothing pending", got);
         return;
      end
      want = pending_headers.pop_front();
      checked++;
      for (int k = 0; k < 7; k++) begin
         if (got[k] !== want[k]) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR: header %0d byte %0d expected %02h got %02h",
                        checked, k, want[k], got[k]);
         end
      end
   endfunction

   function int pending();
      return pending_headers.size();
   endfunction
endclass

module tb_top;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;  // past the last register
   localparam logic [PROFILE_W-1:0] PROFILE_LC = 8'd1;
   localparam int RANDOM_FRAMES = 750;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PAYLOAD_W-1:0]  req_payload_length = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_header_byte_0, rsp_header_byte_1, rsp_header_byte_2;
   logic [BYTE_W-1:0]     rsp_header_byte_3, rsp_header_byte_4, rsp_header_byte_5;
   logic [BYTE_W-1:0]     rsp_header_byte_6;

   header_scoreboard headers = new();

   int  cycle_count = 0;
   int  frames_sent = 0;
   int  settings_applied = 0;
   int  long_holds = 0;
   int  input_stall_cycles = 0;
   bit  long_hold_wanted = 1'b0;

   adts_header_builder DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_header_byte_0  (rsp_header_byte_0),
      .rsp_header_byte_1  (rsp_header_byte_1),
      .rsp_header_byte_2  (rsp_header_byte_2),
      .rsp_header_byte_3  (rsp_header_byte_3),
      .rsp_header_byte_4  (rsp_header_byte_4),
      .rsp_header_byte_5  (rsp_header_byte_5),
      .rsp_header_byte_6  (rsp_header_byte_6)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog, far beyond the slowest legal run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // result monitor, values read right after the edge are the ones the edge sampled
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            headers.check_header({rsp_header_byte_0, rsp_header_byte_1, rsp_header_byte_2,
                                  rsp_header_byte_3, rsp_header_byte_4, rsp_header_byte_5,
                                  rsp_header_byte_6});
         if (req_valid && req_stall)
            input_stall_cycles++;
      end
   end

   // receiver: stretches of its own stall patterns, plus long hold-offs on request
   initial begin : receiver
      stall_kind_type kind;
      int             span;
      int             hold_left;
      kind      = STALL_NONE;
      span      = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && long_hold_wanted) begin
            hold_left        = $urandom_range(60, 120);
            long_hold_wanted = 1'b0;
            long_holds++;
         end
         if (hold_left > 0) begin
            // counted hold-off, lets both stages fill and back up the input
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (span == 0) begin
               kind = stall_kind_type'($urandom_range(0, 3));
               span = $urandom_range(5, 40);
            end
            span--;
            case (kind)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
               STALL_PERIODIC: rsp_stall <= (span % 3 == 0);
               default:        rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // offer one frame and hold it until the block takes it; valid stays high afterwards
   task automatic send_frame(input logic [PAYLOAD_W-1:0] len);
      req_valid          <= 1'b1;
      req_payload_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      headers.note_frame(len);
      frames_sent++;
   endtask

   // stop offering and wait for every pending header to come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (headers.pending() != 0) @(posedge clock);
   endtask

   // one register write per edge, enable left high for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      headers.set_register(idx, data);
   endtask

   // new setting only while the block is empty
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] prof,
                                input logic [CSR_DATA_W-1:0] rate,
                                input logic [CSR_DATA_W-1:0] chans);
      wait_idle();
      write_reg(CSR_PROFILE_CODE, prof);
      write_reg(CSR_SAMPLE_RATE, rate);
      write_reg(CSR_CHANNEL_COUNT, chans);
      // now and then a write past the register file, which must change nothing
      if ($urandom_range(0, 7) == 0)
         write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   initial begin : stimulus
      int                    directed_frames;
      int                    random_sent;
      int                    phase_len;
      int                    burst_left;
      int                    gap;
      int                    holds_asked;
      int                    pick;
      logic [CSR_DATA_W-1:0] prof;
      logic [CSR_DATA_W-1:0] rate;
      logic [CSR_DATA_W-1:0] chans;
      logic [PAYLOAD_W-1:0]  len;

      random_sent = 0;
      holds_asked = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults (lc, 44100, stereo) with payload extremes and wrap past 8184
      send_frame(13'd0);
      send_frame(13'd1);
      send_frame(13'd8184);
      send_frame(13'd8185);
      send_frame(13'd8191);
      send_frame(13'h1555);
      send_frame(13'h0aaa);
      send_frame(13'd2041);

      // write past the last register, nothing may move
      wait_idle();
      write_reg(CSR_UNUSED, 18'h3ffff);
      csr_write_enable <= 1'b0;
      send_frame(13'd100);

      // each profile, table ends, he halving, hev2 channel halving, unmatched rates
      apply_setting(CSR_DATA_W'(PROFILE_MAIN), 18'd96000, 18'd1);
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_SSR), 18'd7350, 18'd7);
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_LTP), 18'd88200, 18'd0);
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_HE), 18'd96000, 18'd8);    // halves to 48000
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(18'h3ff1c, 18'd88200, 18'd15);                 // upper bits masked, hev2
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_HEV2), 18'd44101, 18'd1);  // truncating halves
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_HE), 18'd7351, 18'd3);     // halved rate not in table
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(18'd255, 18'h3ffff, 18'd15);                   // undefined profile, top rate
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(18'd5, 18'd0, 18'd9);                          // channel count wraps to 1
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      apply_setting(CSR_DATA_W'(PROFILE_LC), 18'd12345, 18'h3fff8); // channels masked to 8
      send_frame(PAYLOAD_W'($urandom_range(0, 8184)));
      directed_frames = frames_sent;

      // random phases: new setting, then bursts of frames with gaps
      while (random_sent < RANDOM_FRAMES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            // well-formed: defined profile, table rate (doubled for he), 1..8 channels
            case ($urandom_range(0, 5))
               0:       prof = CSR_DATA_W'(PROFILE_MAIN);
               1:       prof = CSR_DATA_W'(PROFILE_LC);
               2:       prof = CSR_DATA_W'(PROFILE_SSR);
               3:       prof = CSR_DATA_W'(PROFILE_LTP);
               4:       prof = CSR_DATA_W'(PROFILE_HE);
               default: prof = CSR_DATA_W'(PROFILE_HEV2);
            endcase
            rate = rate_entry(SFI_W'($urandom_range(0, RATE_COUNT - 1)));
            if (prof == PROFILE_HE || prof == PROFILE_HEV2)
               rate = CSR_DATA_W'((rate << 1) + $urandom_range(0, 1));
            chans = CSR_DATA_W'($urandom_range(1, 8));
         end else if (pick <= 7) begin
            prof  = CSR_DATA_W'($urandom_range(0, 31));
            rate  = CSR_DATA_W'($urandom_range(0, 18'h3ffff));
            chans = CSR_DATA_W'($urandom_range(0, 15));
         end else if (pick == 8) begin
            prof  = $urandom_range(0, 1) ? 18'd255 : 18'd0;
            rate  = $urandom_range(0, 1) ? 18'h3ffff : 18'd0;
            chans = $urandom_range(0, 1) ? 18'd15 : 18'd0;
         end else begin
            // garbage above the register widths
            prof  = CSR_DATA_W'($urandom);
            rate  = CSR_DATA_W'($urandom);
            chans = CSR_DATA_W'($urandom);
         end
         apply_setting(prof, rate, chans);

         // long result hold-offs while the sender keeps offering
         if ((holds_asked == 0 && random_sent >= 150) ||
             (holds_asked == 1 && random_sent >= 500)) begin
            long_hold_wanted = 1'b1;
            holds_asked++;
         end

         phase_len  = $urandom_range(10, 60);
         burst_left = $urandom_range(1, 20);
         for (int i = 0; i < phase_len && random_sent < RANDOM_FRAMES; i++) begin
            if ($urandom_range(0, 15) == 0)
               len = $urandom_range(0, 1) ? PAYLOAD_W'($urandom_range(8185, 8191))
                                          : PAYLOAD_W'($urandom);
            else
               len = PAYLOAD_W'($urandom_range(0, 8184));
            send_frame(len);
            random_sent++;
            burst_left--;
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 20);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d frames (%0d directed) over %0d register settings",
               frames_sent, directed_frames, settings_applied);
      $display("%0d headers compared, %0d long result hold-offs, %0d cycles of input backpressure",
               headers.checked, long_holds, input_stall_cycles);
      if (headers.failures == 0 && headers.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
